/* hw/rtl/wialu_pkg.sv */
package wialu_pkg;

  localparam int unsigned WordW = 128;
  localparam int unsigned OpW   = 4;

  localparam logic [OpW-1:0] OP_ADD = 4'd0;
  localparam logic [OpW-1:0] OP_SUB = 4'd1;
  localparam logic [OpW-1:0] OP_MUL = 4'd2;
  localparam logic [OpW-1:0] OP_DIV = 4'd3;
  localparam logic [OpW-1:0] OP_AND = 4'd4;
  localparam logic [OpW-1:0] OP_OR  = 4'd5;
  localparam logic [OpW-1:0] OP_XOR = 4'd6;
  localparam logic [OpW-1:0] OP_NOT = 4'd7;
  localparam logic [OpW-1:0] OP_SHL = 4'd8;
  localparam logic [OpW-1:0] OP_SAR = 4'd9;
  localparam logic [OpW-1:0] OP_ROL = 4'd10;
  localparam logic [OpW-1:0] OP_ROR = 4'd11;
  localparam logic [OpW-1:0] OP_CMP = 4'd12;

  typedef struct packed {
    logic [3:0]     operation;
    logic [63:0]    a_hi;
    logic [63:0]    a_lo;
    logic [63:0]    b_hi;
    logic [63:0]    b_lo;
  } req_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    logic        status;
    logic        is_greater;
    logic        is_equal;
  } rsp_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic             gt;
    logic             eq;
    logic             big_shift;
  } work_t;

endpackage

/* hw/rtl/wialu_if.sv */
interface wialu_req_if;
  logic            valid;
  logic            ready;
  wialu_pkg::req_t payload;
  modport source  (output valid, output payload, input ready);
  modport sink    (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

interface wialu_rsp_if;
  logic            valid;
  logic            ready;
  wialu_pkg::rsp_t payload;
  modport source  (output valid, output payload, input ready);
  modport sink    (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

/* hw/rtl/wide_integer_alu_128_unit.sv */
// Channel | Dir | Payload
// req     | in  | operation, a_hi, a_lo, b_hi, b_lo
// rsp     | out | result_hi, result_lo, status, is_greater, is_equal
// Logic ops, add, sub, shifts and rotates pass through the front register, the queue and the back's output state.
// Multiply iterates in the single 32x32 partial-product unit before the output state.
// Divide iterates in the one-bit-per-cycle restoring divider, then a sign fix-up state.
// The front stage and a two-entry queue keep taking requests while the back works, until both are full.
// rst is synchronous and clears all handshake state; a stalled response holds.
module wide_integer_alu_128_unit (
  input  logic        clk,
  input  logic        rst,
  wialu_req_if.sink   req,
  wialu_rsp_if.source rsp
);
  logic             f_valid;
  logic             f_ready;
  wialu_pkg::work_t f_data;
  logic             b_valid;
  logic             b_ready;
  wialu_pkg::work_t b_data;

  wialu_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  wialu_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  wialu_back u_back (
    .clk(clk), .rst(rst),
    .w_valid(b_valid), .w_ready(b_ready), .w_data(b_data), .rsp(rsp)
  );
endmodule

/* hw/rtl/wialu_front.sv */
module wialu_front (
  input  logic               clk,
  input  logic               rst,
  wialu_req_if.sink          req,
  output logic               q_valid,
  input  logic               q_ready,
  output wialu_pkg::work_t   q_data
);
  logic [127:0] a;
  logic [127:0] b;
  logic         gt;

  assign a = {req.payload.a_hi, req.payload.a_lo};
  assign b = {req.payload.b_hi, req.payload.b_lo};
  assign gt = $signed(a) > $signed(b);
  assign req.ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (req.ready) begin
      q_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      q_data.operation <= req.payload.operation;
      q_data.a         <= a;
      q_data.b         <= b;
      q_data.gt        <= gt;
      q_data.eq        <= (a == b);
      q_data.big_shift <= (req.payload.b_lo[63:7] != '0);
    end
  end
endmodule

/* hw/rtl/wialu_queue.sv */
module wialu_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wialu_pkg::work_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output wialu_pkg::work_t out_data
);
  wialu_pkg::work_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (out_valid && out_ready) rptr <= ~rptr;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end
endmodule

/* hw/rtl/wialu_back.sv */
module wialu_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             w_valid,
  output logic             w_ready,
  input  wialu_pkg::work_t w_data,
  wialu_rsp_if.source      rsp
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]   state;
  logic [127:0] a;
  logic [127:0] b;
  logic [127:0] acc;
  logic [127:0] rem;
  logic [127:0] num;
  logic [6:0]   cnt;
  logic [1:0]   mstep;
  logic         neg_q;
  logic         gt;
  logic         eq;
  logic         zdiv;

  logic [127:0] simple;
  logic [127:0] a_abs;
  logic [127:0] b_abs;
  logic [128:0] rem_sh;
  logic [128:0] diff;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  wialu_pkg::work_t w;

  assign w = w_data;
  assign a_abs = w.a[127] ? -w.a : w.a;
  assign b_abs = w.b[127] ? -w.b : w.b;

  always_comb begin
    simple = '0;
    case (w.operation)
      wialu_pkg::OP_ADD: simple = w.a + w.b;
      wialu_pkg::OP_SUB: simple = w.a - w.b;
      wialu_pkg::OP_AND: simple = w.a & w.b;
      wialu_pkg::OP_OR:  simple = w.a | w.b;
      wialu_pkg::OP_XOR: simple = w.a ^ w.b;
      wialu_pkg::OP_NOT: simple = ~w.a;
      wialu_pkg::OP_SHL: simple = w.big_shift ? '0 : w.a << w.b[6:0];
      wialu_pkg::OP_SAR: simple = w.big_shift ? {128{w.a[127]}}
                                              : 128'($signed(w.a) >>> w.b[6:0]);
      wialu_pkg::OP_ROL: simple = {w.a[126:0], w.a[127]};
      wialu_pkg::OP_ROR: simple = {w.a[0], w.a[127:1]};
      default:           simple = '0;
    endcase
  end

  // One 32x32 partial product per cycle, accumulated into a full wrap product.
  always_comb begin
    logic [31:0] x;
    logic [31:0] y;
    x = a[{mstep, 5'd0} +: 32];
    y = b[{cnt[1:0], 5'd0} +: 32];
    pp = 64'(x) * 64'(y);
    pp_sh = 128'(pp) << ({1'b0, mstep} + {1'b0, cnt[1:0]}) * 32;
  end

  assign rem_sh = {rem, num[127]};
  assign diff   = rem_sh - {1'b0, b};

  assign w_ready = (state == S_IDLE) && !rsp.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (w_valid && w_ready) begin
            gt <= w.gt;
            eq <= w.eq;
            a  <= w.a;
            // The divider works on the divisor magnitude.
            b  <= (w.operation == wialu_pkg::OP_DIV) ? b_abs : w.b;
            acc <= '0;
            rem <= '0;
            cnt <= '0;
            mstep <= '0;
            zdiv <= 1'b0;
            if (w.operation == wialu_pkg::OP_MUL) begin
              state <= S_MUL;
            end else if (w.operation == wialu_pkg::OP_DIV) begin
              if (w.b == '0) begin
                zdiv  <= 1'b1;
                state <= S_OUT;
              end else begin
                num   <= a_abs;
                neg_q <= w.a[127] ^ w.b[127];
                state <= S_DIV;
              end
            end else begin
              acc   <= simple;
              state <= S_OUT;
            end
          end
        end
        S_MUL: begin
          if ({1'b0, mstep} + {1'b0, cnt[1:0]} < 3'd4) acc <= acc + pp_sh;
          cnt[1:0] <= cnt[1:0] + 2'd1;
          if (cnt[1:0] == 2'd3) begin
            mstep <= mstep + 2'd1;
            if (mstep == 2'd3) state <= S_OUT;
          end
        end
        S_DIV: begin
          num <= {num[126:0], 1'b0};
          if (!diff[128]) begin
            rem <= diff[127:0];
            acc <= {acc[126:0], 1'b1};
          end else begin
            rem <= rem_sh[127:0];
            acc <= {acc[126:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd127) state <= S_FIX;
        end
        S_FIX: begin
          if (neg_q) acc <= -acc;
          state <= S_OUT;
        end
        S_OUT: begin
          rsp.valid <= 1'b1;
          rsp.payload.result_hi  <= acc[127:64];
          rsp.payload.result_lo  <= acc[63:0];
          rsp.payload.status     <= zdiv;
          rsp.payload.is_greater <= gt;
          rsp.payload.is_equal   <= eq;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
